// ----- design/lbe_pkg.sv -----
// Shared types, constants and functions for the addressable LED bit encoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package lbe_pkg;

    localparam int STRIP_NUM      = 3;
    localparam int ORDER_REGS     = 3;
    localparam int DUTY_W         = 10;
    localparam int ORDER_W        = 2;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 10;
    localparam int SLOT_CNT_W     = 6;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ORDER_A   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ORDER_B   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ORDER_C   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ZERO_DUTY = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ONE_DUTY  = 3'd4;

    // color orders
    localparam logic [ORDER_W-1:0] ORDER_GRB  = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_GRBW = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_RGB  = 2'd2;
    localparam logic [ORDER_W-1:0] ORDER_WRGB = 2'd3;

    localparam logic [DUTY_W-1:0] ZERO_DUTY_RST = 10'd31;
    localparam logic [DUTY_W-1:0] ONE_DUTY_RST  = 10'd72;

    localparam logic [SLOT_CNT_W-1:0] SLOTS_SHORT = 6'd24;
    localparam logic [SLOT_CNT_W-1:0] SLOTS_LONG  = 6'd32;

    typedef struct packed {
        logic [ORDER_REGS-1:0][ORDER_W-1:0] order;
        logic [DUTY_W-1:0]                  zero_duty;
        logic [DUTY_W-1:0]                  one_duty;
    } cfg_t;

    // one pixel after gamma and packing; word is left-aligned
    typedef struct packed {
        logic [31:0] word;
        logic        long_word;
        logic        frame_end;
    } pix_item_t;

    function automatic logic [7:0] gamma8(input logic [7:0] c);
        logic [15:0] sq;
        logic [15:0] sum;
        sq  = {8'd0, c} * {8'd0, c};
        sum = sq + {8'd0, c};
        return sum[15:8];
    endfunction

endpackage
`default_nettype wire

// ----- design/lbe_front.sv -----
// Front end: accepts pixels, gamma-corrects the channels and packs them in the strip's order.
// Depends on lbe_pkg; feeds lbe_queue.
`default_nettype none
module lbe_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lbe_pkg::cfg_t     cfg,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,
    input  wire logic [1:0]        s_tuser,
    input  wire logic              s_tlast,
    output logic                   push,
    output lbe_pkg::pix_item_t     push_item,
    input  wire logic              queue_full
);
    import lbe_pkg::*;

    logic        valid_reg, valid_next;
    logic [31:0] pix_reg;
    logic [1:0]  strip_reg;
    logic        fend_reg;
    logic [ORDER_W-1:0] order;
    logic [7:0]  w, r, g, b;

    assign s_tready = !valid_reg || !queue_full;
    assign push     = valid_reg && !queue_full;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            pix_reg   <= s_tdata;
            strip_reg <= s_tuser;
            fend_reg  <= s_tlast;
        end
    end

    // unknown strips fall back to grb
    always_comb
    begin
        order = ORDER_GRB;
        if (32'(strip_reg) < STRIP_NUM && 32'(strip_reg) < ORDER_REGS)
        begin
            order = cfg.order[strip_reg];
        end
    end

    assign w = gamma8(pix_reg[31:24]);
    assign r = gamma8(pix_reg[23:16]);
    assign g = gamma8(pix_reg[15:8]);
    assign b = gamma8(pix_reg[7:0]);

    always_comb
    begin
        push_item.frame_end = fend_reg;
        case (order)
            ORDER_GRBW:
            begin
                push_item.word      = {g, r, b, w};
                push_item.long_word = 1'b1;
            end
            ORDER_RGB:
            begin
                push_item.word      = {r, g, b, 8'd0};
                push_item.long_word = 1'b0;
            end
            ORDER_WRGB:
            begin
                push_item.word      = {w, r, g, b};
                push_item.long_word = 1'b1;
            end
            default:
            begin
                push_item.word      = {g, r, b, 8'd0};
                push_item.long_word = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- design/lbe_queue.sv -----
// Two-entry queue of packed pixels between the front end and the bit serializer.
// Depends on lbe_pkg.
`default_nettype none
module lbe_queue
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire lbe_pkg::pix_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output logic                    not_empty,
    output lbe_pkg::pix_item_t      pop_item
);
    import lbe_pkg::*;

    pix_item_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ----- design/lbe_back.sv -----
// Back end: shifts a packed pixel out one bit slot per cycle, while the receiver is ready, into the output register.
// Depends on lbe_pkg; reads from lbe_queue.
`default_nettype none
module lbe_back
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lbe_pkg::cfg_t      cfg,
    input  wire logic               not_empty,
    input  wire lbe_pkg::pix_item_t pop_item,
    output logic                    pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [15:0]             m_tdata,   // duty_value [9:0], data_bit [10], zeros above
    output logic                    m_tlast
);
    import lbe_pkg::*;

    logic [31:0]            word_reg, word_next;
    logic [SLOT_CNT_W-1:0]  rem_reg, rem_next;
    logic                   hold_reg, hold_next;
    logic                   out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0]      duty_reg, duty_next;
    logic                   bit_reg, bit_next;
    logic                   last_reg, last_next;
    logic                   busy, advance, finishing;

    assign busy      = (rem_reg != '0) || hold_reg;
    assign advance   = !out_valid_reg || m_tready;
    assign finishing = advance && (((rem_reg == 6'd1) && !hold_reg) ||
                                   ((rem_reg == '0) && hold_reg));
    assign pop       = not_empty && (!busy || finishing);

    always_comb
    begin
        word_next      = word_reg;
        rem_next       = rem_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg;
        duty_next      = duty_reg;
        bit_next       = bit_reg;
        last_next      = last_reg;
        if (advance)
        begin
            out_valid_next = busy;
            if (rem_reg != '0)
            begin
                bit_next  = word_reg[31];
                duty_next = word_reg[31] ? cfg.one_duty : cfg.zero_duty;
                last_next = (rem_reg == 6'd1) && !hold_reg;
                word_next = {word_reg[30:0], 1'b0};
                rem_next  = rem_reg - 6'd1;
            end
            else if (hold_reg)
            begin
                // line-low hold slot after the frame's last pixel
                bit_next  = 1'b0;
                duty_next = '0;
                last_next = 1'b1;
                hold_next = 1'b0;
            end
        end
        if (pop)
        begin
            word_next = pop_item.word;
            rem_next  = pop_item.long_word ? SLOTS_LONG : SLOTS_SHORT;
            hold_next = pop_item.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            hold_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            hold_reg      <= hold_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        duty_reg <= duty_next;
        bit_reg  <= bit_next;
        last_reg <= last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, bit_reg, duty_reg};
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

// ----- design/addressable_led_bit_encoder.sv -----
// Top level of the addressable LED bit encoder: configuration registers and the
// front end, queue and serializer. Depends on lbe_pkg, lbe_front, lbe_queue, lbe_back.
//
// Input stream (s_*): one transfer per pixel. s_tdata carries the WRGB pixel,
// s_tuser the strip number, s_tlast marks the last pixel of a frame.
// Output stream (m_*): one transfer per bit slot, most significant bit first:
// 24 slots for GRB/RGB strips, 32 for GRBW/WRGB, plus one hold slot with duty 0
// after a frame's last pixel. m_tlast is high on the final slot of each pixel.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0-2 strip color
// orders, 3 zero duty, 4 one duty); other indexes are ignored. Write only when idle.
// Path: the first slot of a pixel passes the front-end register, a queue entry and the output register.
// Throughput: one slot per cycle while the receiver is ready, set by the
// serializer; a two-entry queue lets the next pixels be taken meanwhile.
// Reset clears all queued work and restores orders to GRB, duties to 31 and 72.
// When the receiver stalls, the output slot holds and the queue fills, then
// s_tready drops until slots move again.
`default_nettype none
module addressable_led_bit_encoder
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [31:0]                        s_tdata,   // pixel_color
    input  wire logic [1:0]                         s_tuser,   // strip_index
    input  wire logic                               s_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [15:0]                             m_tdata,   // duty_value [9:0], data_bit [10]
    output logic                                    m_tlast,
    input  wire logic                               cfg_we,
    input  wire logic [lbe_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [lbe_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import lbe_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      push, queue_full, pop, not_empty;
    pix_item_t push_item, pop_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_ORDER_A:   cfg_next.order[0]  = cfg_wdata[ORDER_W-1:0];
                REG_ORDER_B:   cfg_next.order[1]  = cfg_wdata[ORDER_W-1:0];
                REG_ORDER_C:   cfg_next.order[2]  = cfg_wdata[ORDER_W-1:0];
                REG_ZERO_DUTY: cfg_next.zero_duty = cfg_wdata[DUTY_W-1:0];
                REG_ONE_DUTY:  cfg_next.one_duty  = cfg_wdata[DUTY_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.order     <= {ORDER_REGS{ORDER_GRB}};
            cfg_reg.zero_duty <= ZERO_DUTY_RST;
            cfg_reg.one_duty  <= ONE_DUTY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lbe_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    lbe_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (not_empty),
        .pop_item   (pop_item)
    );

    lbe_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .not_empty  (not_empty),
        .pop_item   (pop_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for addressable_led_bit_encoder: a directed table, then random
// pixels over several register settings, every bit slot compared with a local predictor.
// Depends on lbe_pkg and addressable_led_bit_encoder; needs no files or arguments.
`timescale 1ns / 100ps
module tb;
    import lbe_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int PHASES       = 6;
    localparam int PHASE_PIXELS = 48;
    localparam int END_CYCLES   = 40;
    localparam int DIR_ROWS     = 25;

    // indexes with no register behind them
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [DUTY_W-1:0] DUTY_HOLD = 10'd0;
    localparam logic [DUTY_W-1:0] DUTY_MAX  = 10'd1023;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              data_bit;
        logic              last;
    } slot_t;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_e;

    // typed rows carry their slots directly: every data slot has data_bit and duty
    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] wdata;
        logic [31:0]           pixel;
        logic [1:0]            strip;
        logic                  fend;
        logic                  typed;
        logic                  data_bit;
        logic [DUTY_W-1:0]     duty;
        logic [SLOT_CNT_W-1:0] slots;
    } dir_row_t;

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // reset settings: GRB everywhere, duties 31 and 72
        '{ROW_PIXEL, REG_ORDER_A, 10'd0, 32'h0000_0000, 2'd0, 1'b0,
          1'b1, 1'b0, ZERO_DUTY_RST, SLOTS_SHORT},
        '{ROW_PIXEL, REG_ORDER_A, 10'd0, 32'hFFFF_FFFF, 2'd0, 1'b1,
          1'b1, 1'b1, ONE_DUTY_RST, SLOTS_SHORT},
        // strip without an order register falls back to GRB
        '{ROW_PIXEL, REG_ORDER_A, 10'd0, 32'hFFFF_FFFF, 2'd3, 1'b0,
          1'b1, 1'b1, ONE_DUTY_RST, SLOTS_SHORT},
        '{ROW_PIXEL, REG_ORDER_A, 10'd0, 32'h1234_5678, 2'd1, 1'b0,
          1'b0, 1'b0, 10'd0, 6'd0},
        '{ROW_WRITE, REG_ORDER_A, {8'd0, ORDER_WRGB}, 32'h0, 2'd0, 1'b0,
          1'b0, 1'b0, 10'd0, 6'd0},
        '{ROW_WRITE, REG_ORDER_B, {8'd0, ORDER_GRBW}, 32'h0, 2'd0, 1'b0,
          1'b0, 1'b0, 10'd0, 6'd0},
        '{ROW_WRITE, REG_ORDER_C, {8'd0, ORDER_RGB}, 32'h0, 2'd0, 1'b0,
          1'b0, 1'b0, 10'd0, 6'd0},
        '{ROW_WRITE, REG_ZERO_DUTY, 10'd0, 32'h0, 2'd0, 1'b0,
          1'b0, 1'b0, 10'd0, 6'd0},
        '{ROW_WRITE, REG_ONE_DUTY, DUTY_MAX, 32'h0, 2'd0, 1'b0,
          1'b0, 1'b0, 10'd0, 6'd0},
        '{ROW_PIXEL, REG_ORDER_A, 10'd0, 32'hFFFF_FFFF, 2'd0, 1'b0,
          1'b1, 1'b1, DUTY_MAX, SLOTS_LONG},
        '{ROW_PIXEL, REG_ORDER_A, 10'd0, 32'h0000_0000, 2'd1, 1'b1,
          1'b1, 1'b0, 10'd0, SLOTS_LONG},
        '{ROW_PIXEL, REG_ORDER_A, 10'd0, 32'h00FF_0000, 2'd2, 1'b0,
          1'b0, 1'b0, 10'd0, 6'd0},
        '{ROW_PIXEL, REG_ORDER_A, 10'd0, 32'hFF00_0000, 2'd0, 1'b0,
          1'b0, 1'b0, 10'd0, 6'd0},
        // white is dropped on an RGB strip
        '{ROW_PIXEL, REG_ORDER_A, 10'd0, 32'hFF00_0000, 2'd2, 1'b1,
          1'b1, 1'b0, 10'd0, SLOTS_SHORT},
        '{ROW_PIXEL, REG_ORDER_A, 10'd0, 32'h0102_0380, 2'd1, 1'b0,
          1'b0, 1'b0, 10'd0, 6'd0},
        '{ROW_PIXEL, REG_ORDER_A, 10'd0, 32'h1234_5678, 2'd3, 1'b1,
          1'b0, 1'b0, 10'd0, 6'd0},
        '{ROW_WRITE, REG_SPARE_LO, DUTY_MAX, 32'h0, 2'd0, 1'b0,
          1'b0, 1'b0, 10'd0, 6'd0},
        '{ROW_WRITE, REG_SPARE_HI, 10'd0, 32'h0, 2'd0, 1'b0,
          1'b0, 1'b0, 10'd0, 6'd0},
        '{ROW_PIXEL, REG_ORDER_A, 10'd0, 32'hA5C3_0FF0, 2'd0, 1'b1,
          1'b0, 1'b0, 10'd0, 6'd0},
        '{ROW_WRITE, REG_ZERO_DUTY, DUTY_MAX, 32'h0, 2'd0, 1'b0,
          1'b0, 1'b0, 10'd0, 6'd0},
        '{ROW_WRITE, REG_ONE_DUTY, 10'd0, 32'h0, 2'd0, 1'b0,
          1'b0, 1'b0, 10'd0, 6'd0},
        '{ROW_PIXEL, REG_ORDER_A, 10'd0, 32'h0F0F_0F0F, 2'd1, 1'b0,
          1'b0, 1'b0, 10'd0, 6'd0},
        // upper data bits of an order write are don't-care
        '{ROW_WRITE, REG_ORDER_A, {8'hFF, ORDER_GRB}, 32'h0, 2'd0, 1'b0,
          1'b0, 1'b0, 10'd0, 6'd0},
        '{ROW_PIXEL, REG_ORDER_A, 10'd0, 32'h80FF_7F01, 2'd0, 1'b1,
          1'b0, 1'b0, 10'd0, 6'd0},
        '{ROW_PIXEL, REG_ORDER_A, 10'd0, 32'h7F80_FE01, 2'd2, 1'b0,
          1'b0, 1'b0, 10'd0, 6'd0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;   // pixel_color
    logic [1:0]            s_tuser;   // strip_index
    logic                  s_tlast;   // frame_end
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;   // duty_value [9:0], data_bit [10]
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // shadow of the block's registers
    logic [ORDER_W-1:0] strip_order [ORDER_REGS];
    logic [DUTY_W-1:0]  zero_duty_cfg;
    logic [DUTY_W-1:0]  one_duty_cfg;

    slot_t expected_slots [$];
    int    mismatches    = 0;
    int    slots_checked = 0;
    int    pixels_sent   = 0;
    int    frames_ended  = 0;
    int    idle_cycles   = 0;
    int    rx_hold       = 0;
    bit    rx_calm       = 1'b0;
    bit    tx_calm       = 1'b0;
    bit    tx_busy       = 1'b0;

    addressable_led_bit_encoder i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    function automatic logic [7:0] gamma_level(input logic [7:0] c);
        int unsigned v;
        v = (int'(c) * int'(c) + int'(c)) / 256;
        return v[7:0];
    endfunction

    // one slot per bit, msb first, then the hold slot when the frame ends
    function automatic void queue_slots(input logic [31:0] word, input int nbits,
                                        input logic fend, input logic [DUTY_W-1:0] zero_d,
                                        input logic [DUTY_W-1:0] one_d);
        logic lit;
        for (int k = 0; k < nbits; k++)
        begin
            lit = word[nbits - 1 - k];
            expected_slots.push_back(slot_t'{lit ? one_d : zero_d, lit,
                                             !fend && k == nbits - 1});
        end
        if (fend)
            expected_slots.push_back(slot_t'{DUTY_HOLD, 1'b0, 1'b1});
    endfunction

    function automatic void encode_pixel(input logic [31:0] pixel, input logic [1:0] strip,
                                         input logic fend);
        logic [7:0]         w;
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
        logic [ORDER_W-1:0] ord;
        w   = gamma_level(pixel[31:24]);
        r   = gamma_level(pixel[23:16]);
        g   = gamma_level(pixel[15:8]);
        b   = gamma_level(pixel[7:0]);
        ord = (strip < STRIP_NUM) ? strip_order[strip] : ORDER_GRB;
        case (ord)
            ORDER_GRBW: queue_slots({g, r, b, w}, SLOTS_LONG, fend, zero_duty_cfg, one_duty_cfg);
            ORDER_RGB:  queue_slots({8'd0, r, g, b}, SLOTS_SHORT, fend, zero_duty_cfg,
                                    one_duty_cfg);
            ORDER_WRGB: queue_slots({w, r, g, b}, SLOTS_LONG, fend, zero_duty_cfg, one_duty_cfg);
            default:    queue_slots({8'd0, g, r, b}, SLOTS_SHORT, fend, zero_duty_cfg,
                                    one_duty_cfg);
        endcase
    endfunction

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 4))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [DUTY_W-1:0] pick_duty();
        case ($urandom_range(0, 3))
            0:       return 10'd0;
            1:       return DUTY_MAX;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    // cfg_we is left high; the next pixel transfer lowers it
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] wdata);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= wdata;
        @(posedge clk);
        case (addr)
            REG_ORDER_A:   strip_order[0] = wdata[ORDER_W-1:0];
            REG_ORDER_B:   strip_order[1] = wdata[ORDER_W-1:0];
            REG_ORDER_C:   strip_order[2] = wdata[ORDER_W-1:0];
            REG_ZERO_DUTY: zero_duty_cfg  = wdata[DUTY_W-1:0];
            REG_ONE_DUTY:  one_duty_cfg   = wdata[DUTY_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic drain_slots();
        if (tx_busy)
            s_tvalid <= 1'b0;
        tx_busy = 1'b0;
        while (expected_slots.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_pixel(input logic [31:0] pixel, input logic [1:0] strip,
                              input logic fend);
        int gap;
        if ($urandom_range(0, 31) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        cfg_we <= 1'b0;
        if (gap > 0)
        begin
            if (tx_busy)
                s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pixel;
        s_tuser  <= strip;
        s_tlast  <= fend;
        tx_busy = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pixels_sent++;
        if (fend)
            frames_ended++;
    endtask

    // output side: check each transfer, then draw the next stall
    always @(posedge clk)
    begin : slot_sink
        slot_t exp_slot;
        logic  ready_next;
        ready_next = m_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_slots.size() == 0)
            begin
                $display("%0t: unexpected slot, expected none, got duty %0d bit %0b last %0b",
                         $time, m_tdata[DUTY_W-1:0], m_tdata[DUTY_W], m_tlast);
                mismatches++;
            end
            else
            begin
                exp_slot = expected_slots.pop_front();
                slots_checked++;
                if (m_tdata[DUTY_W-1:0] !== exp_slot.duty || m_tdata[DUTY_W] !== exp_slot.data_bit
                    || m_tlast !== exp_slot.last || m_tdata[15:DUTY_W+1] !== '0)
                begin
                    $display("%0t: slot mismatch, expected duty %0d bit %0b last %0b pad 0, got duty %0d bit %0b last %0b pad %h",
                             $time, exp_slot.duty, exp_slot.data_bit, exp_slot.last,
                             m_tdata[DUTY_W-1:0], m_tdata[DUTY_W], m_tlast,
                             m_tdata[15:DUTY_W+1]);
                    mismatches++;
                end
            end
            if ($urandom_range(0, 63) == 0)
                rx_calm = !rx_calm;
            rx_hold    = rx_calm ? 0 : $urandom_range(0, 6);
            ready_next = (rx_hold == 0);
        end
        else if (!m_tready)
        begin
            if (rx_hold > 0)
                rx_hold--;
            ready_next = (rx_hold == 0);
        end
        m_tready <= ready_next;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d slots outstanding",
                     $time, STALL_LIMIT, expected_slots.size());
            $display("[addressable_led_bit_encoder] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        dir_row_t    row;
        logic [31:0] pixel;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        for (int s = 0; s < ORDER_REGS; s++)
            strip_order[s] = ORDER_GRB;
        zero_duty_cfg = ZERO_DUTY_RST;
        one_duty_cfg  = ONE_DUTY_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = DIRECTED[i];
            if (row.kind == ROW_WRITE)
            begin
                drain_slots();
                write_reg(row.addr, row.wdata);
            end
            else
            begin
                send_pixel(row.pixel, row.strip, row.fend);
                if (row.typed)
                    queue_slots(row.data_bit ? 32'hFFFF_FFFF : 32'h0, row.slots, row.fend,
                                row.duty, row.duty);
                else
                    encode_pixel(row.pixel, row.strip, row.fend);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            drain_slots();
            write_reg(REG_ORDER_A, 10'($urandom_range(0, 1023)));
            write_reg(REG_ORDER_B, 10'($urandom_range(0, 1023)));
            write_reg(REG_ORDER_C, 10'($urandom_range(0, 1023)));
            write_reg(REG_ZERO_DUTY, pick_duty());
            write_reg(REG_ONE_DUTY, pick_duty());
            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_ADDR_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                          10'($urandom_range(0, 1023)));
            for (int j = 0; j < PHASE_PIXELS; j++)
            begin
                pixel = {pick_channel(), pick_channel(), pick_channel(), pick_channel()};
                send_pixel(pixel, 2'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
                encode_pixel(s_tdata, s_tuser, s_tlast);
            end
        end

        drain_slots();
        repeat (END_CYCLES) @(posedge clk);
        $display("%0d pixels over %0d register settings, %0d frames closed with a hold slot",
                 pixels_sent, PHASES + 1, frames_ended);
        $display("%0d bit slots checked, %0d mismatches", slots_checked, mismatches);
        if (mismatches == 0 && expected_slots.size() == 0)
            $display("[addressable_led_bit_encoder] OK");
        else
            $display("[addressable_led_bit_encoder] ERROR");
        $finish;
    end

endmodule
